// File: sv/lrws_pkg.sv
// Shared types and constants for the line rasterizer with wall stop.
// Used by line_raster_with_wall_stop_core; depends on nothing else.
package lrws_pkg;

	// Field widths fixed by the request and result formats.
	localparam int COORD_W = 11;
	localparam int ERR_W = 13;
	localparam int WALL_MASK_W = 25;

	localparam logic [WALL_MASK_W-1:0] WALL_MASK_RESET = 25'd33084989;

	// Default map geometry.
	localparam int MAP_COLS_DEF = 5;
	localparam int MAP_ROWS_DEF = 5;
	localparam int TILE_PIXELS_DEF = 40;

	// Operation codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef struct packed {
		logic op;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic stop_at_wall;
	} lrws_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic hit_wall;
		logic last;
	} lrws_rsp_t;

endpackage

// File: sv/line_raster_with_wall_stop_core.sv
// Bresenham line stepper over a tile map with optional stop on the first wall tile.
// Depends on lrws_pkg for the request and result types and constants.
//
// Usage:
// - Request channel (in_valid, in_stall, in_req): a start request (op = OP_START)
//   loads the endpoints and the wall mode and gives no result. Each step request
//   (op = OP_STEP) gives one pixel while a line is active, and nothing when idle.
// - Result channel (out_valid, out_stall, out_rsp): one result per step request
//   on an active line; last marks the final pixel (end point reached, or a wall
//   tile or a point outside the map in wall mode).
// - wall_mask_wen / wall_mask_wdata write the 25-bit tile mask; write it only
//   while no line results are pending.
// - Each result is registered in the output register, or in the skid register
//   while the output is stalled. One request per cycle is taken while in_stall
//   is low; the next position is one add/compare step on the line state registers.
// - When the receiver stalls, the output register holds its result and one more
//   result lands in a skid register; in_stall then rises until the skid drains.
// - Reset clears the line state to idle, empties both result registers and loads
//   the default wall mask.
module line_raster_with_wall_stop_core #(
	parameter int MAP_COLS = lrws_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS = lrws_pkg::MAP_ROWS_DEF,
	parameter int TILE_PIXELS = lrws_pkg::TILE_PIXELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wall_mask_wen,
	input logic [lrws_pkg::WALL_MASK_W-1:0] wall_mask_wdata,
	input logic in_valid,
	output logic in_stall,
	input lrws_pkg::lrws_req_t in_req,
	output logic out_valid,
	input logic out_stall,
	output lrws_pkg::lrws_rsp_t out_rsp
);

	localparam int CW = lrws_pkg::COORD_W;
	localparam int EW = lrws_pkg::ERR_W;
	localparam int MW = lrws_pkg::WALL_MASK_W;
	localparam int CMP_W = CW + 1;
	localparam int COL_W = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
	localparam int ROW_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
	localparam int CELLS = MAP_COLS * MAP_ROWS;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CELLS_PAD = 1 << CELL_W;

	// Line state.
	logic [MW-1:0] wall_mask_q;
	logic [CW-1:0] cur_x_q, cur_y_q, target_x_q, target_y_q, delta_x_q, delta_y_q;
	logic signed [EW-1:0] error_q;
	logic active_q, wall_mode_q;

	// Result registers.
	lrws_pkg::lrws_rsp_t out_q, skid_q;
	logic out_valid_q, skid_full_q;

	logic in_accept, out_take, res_valid;
	lrws_pkg::lrws_rsp_t res;

	assign in_stall = skid_full_q;
	assign in_accept = in_valid && !skid_full_q;
	assign out_take = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_rsp = out_q;

	// Start request: absolute deltas and initial error term.
	logic [CW-1:0] ld_dx, ld_dy;
	logic signed [EW-1:0] ld_err;

	always_comb begin
		ld_dx = (in_req.start_x > in_req.end_x) ? in_req.start_x - in_req.end_x
		                                        : in_req.end_x - in_req.start_x;
		ld_dy = (in_req.start_y > in_req.end_y) ? in_req.start_y - in_req.end_y
		                                        : in_req.end_y - in_req.start_y;
		if (ld_dx > ld_dy) begin
			ld_err = $signed({{(EW - CW + 1){1'b0}}, ld_dx[CW-1:1]});
		end else begin
			ld_err = -$signed({{(EW - CW + 1){1'b0}}, ld_dy[CW-1:1]});
		end
	end

	// Tile lookup: column and row counted against constant tile boundaries.
	logic [COL_W-1:0] col_idx;
	logic [ROW_W-1:0] row_idx;
	logic outside;
	logic [CELL_W-1:0] cell_idx;
	logic [CELLS_PAD-1:0] cell_wall;
	logic hit;

	always_comb begin
		col_idx = '0;
		row_idx = '0;
		for (int k = 1; k < MAP_COLS; k++) begin
			if ({1'b0, cur_x_q} >= CMP_W'(k * TILE_PIXELS)) begin
				col_idx = col_idx + COL_W'(1);
			end
		end
		for (int k = 1; k < MAP_ROWS; k++) begin
			if ({1'b0, cur_y_q} >= CMP_W'(k * TILE_PIXELS)) begin
				row_idx = row_idx + ROW_W'(1);
			end
		end
		outside = ({1'b0, cur_x_q} >= CMP_W'(MAP_COLS * TILE_PIXELS))
		       || ({1'b0, cur_y_q} >= CMP_W'(MAP_ROWS * TILE_PIXELS));
	end

	// Tiles beyond the mask width never count as wall.
	for (genvar i = 0; i < CELLS_PAD; i++) begin : g_cell
		if (i < MW && i < CELLS) begin : g_used
			assign cell_wall[i] = wall_mask_q[i];
		end else begin : g_none
			assign cell_wall[i] = 1'b0;
		end
	end

	assign cell_idx = CELL_W'(CELL_W'(row_idx) * CELL_W'(MAP_COLS) + CELL_W'(col_idx));
	assign hit = outside || cell_wall[cell_idx];

	// Step request: emit the current pixel and compute the next position.
	logic step_last, move_x, move_y;
	logic signed [EW-1:0] dx_s, dy_s, err_next;
	logic [CW-1:0] nx, ny;

	always_comb begin
		dx_s = $signed({{(EW - CW){1'b0}}, delta_x_q});
		dy_s = $signed({{(EW - CW){1'b0}}, delta_y_q});
		step_last = (cur_x_q == target_x_q && cur_y_q == target_y_q) || (wall_mode_q && hit);
		move_x = error_q > -dx_s;
		move_y = error_q < dy_s;
		err_next = error_q - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
		nx = (cur_x_q < target_x_q) ? cur_x_q + CW'(1) : cur_x_q - CW'(1);
		ny = (cur_y_q < target_y_q) ? cur_y_q + CW'(1) : cur_y_q - CW'(1);
		res.pixel_x = cur_x_q;
		res.pixel_y = cur_y_q;
		res.hit_wall = hit;
		res.last = step_last;
		res_valid = in_accept && (in_req.op == lrws_pkg::OP_STEP) && active_q;
	end

	// Wall mask register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_mask_q <= lrws_pkg::WALL_MASK_RESET;
		end else if (wall_mask_wen) begin
			wall_mask_q <= wall_mask_wdata;
		end
	end

	// Line state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			target_x_q <= '0;
			target_y_q <= '0;
			delta_x_q <= '0;
			delta_y_q <= '0;
			error_q <= '0;
			active_q <= 1'b0;
			wall_mode_q <= 1'b0;
		end else if (in_accept) begin
			if (in_req.op == lrws_pkg::OP_START) begin
				cur_x_q <= in_req.start_x;
				cur_y_q <= in_req.start_y;
				target_x_q <= in_req.end_x;
				target_y_q <= in_req.end_y;
				delta_x_q <= ld_dx;
				delta_y_q <= ld_dy;
				error_q <= ld_err;
				wall_mode_q <= in_req.stop_at_wall;
				active_q <= 1'b1;
			end else if (active_q) begin
				if (step_last) begin
					active_q <= 1'b0;
				end else begin
					error_q <= err_next;
					if (move_x) begin
						cur_x_q <= nx;
					end
					if (move_y) begin
						cur_y_q <= ny;
					end
				end
			end
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (out_take || !out_valid_q) begin
				if (skid_full_q) begin
					out_valid_q <= 1'b1;
					skid_full_q <= 1'b0;
				end else begin
					out_valid_q <= res_valid;
				end
			end else if (res_valid) begin
				skid_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_full_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

endmodule
